### sv/vsc_pkg.sv
// shared types, constants and register indexes of the voxel sign classifier
package vsc_pkg;

  localparam int NUM_CORNERS = 8;
  localparam int VAL_W       = 32;
  localparam int IDX_W       = 10;
  localparam int SIZE_W      = 31;
  localparam int PROD_W      = SIZE_W + IDX_W;
  localparam int CFG_IDX_W   = 3;
  localparam int MASK_W      = 3;

  // grid extent along each axis; cells at or beyond it are never kept
  localparam int CELLS_PER_AXIS = 1024;
  localparam int GRID_CMP_W     = 17;

  localparam logic signed [VAL_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] S32_MIN = 32'sh8000_0000;

  localparam logic [MASK_W-1:0] KEEP_MASK_RESET = 3'd7;
  localparam logic [SIZE_W-1:0] CELL_SIZE_RESET = 31'd65536;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd4;

  // keep mask bit positions
  localparam int KEEP_CROSSING = 0;
  localparam int KEEP_INSIDE   = 1;
  localparam int KEEP_OUTSIDE  = 2;

  typedef struct packed {
    logic pos;
    logic neg;
  } lane_flags_t;

  typedef struct packed {
    logic kept;
    logic interior;
    logic outside;
    logic crossing;
  } cls_t;

endpackage

### sv/vsc_corner_lane.sv
// one corner lane: sign test of a single corner value
module vsc_corner_lane (
  input  logic signed [vsc_pkg::VAL_W-1:0] corner,
  output vsc_pkg::lane_flags_t             flags
);

  always_comb begin
    flags.neg = corner[vsc_pkg::VAL_W-1];
    flags.pos = !corner[vsc_pkg::VAL_W-1] && (corner != '0);
  end

endmodule

### sv/vsc_axis_lane.sv
// one axis lane: registered index product, then origin add with saturation
module vsc_axis_lane (
  input  logic                              clk,
  input  logic                              load,
  input  logic [vsc_pkg::IDX_W-1:0]         cell_idx,
  input  logic [vsc_pkg::SIZE_W-1:0]        cell_size,
  input  logic signed [vsc_pkg::VAL_W-1:0]  origin,
  output logic signed [vsc_pkg::VAL_W-1:0]  coord
);

  localparam int SUM_W = vsc_pkg::PROD_W + 2;

  logic [vsc_pkg::PROD_W-1:0] prod;
  logic [SUM_W-1:0]           sum;

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= vsc_pkg::PROD_W'(cell_size) * vsc_pkg::PROD_W'(cell_idx);
    end
  end

  always_comb begin
    sum = {{(SUM_W-vsc_pkg::VAL_W){origin[vsc_pkg::VAL_W-1]}}, origin}
        + {2'b00, prod};
    // top bits must all match the sign bit, else clamp
    if (!sum[SUM_W-1] && (|sum[SUM_W-2:vsc_pkg::VAL_W-1])) begin
      coord = vsc_pkg::S32_MAX;
    end else if (sum[SUM_W-1] && !(&sum[SUM_W-2:vsc_pkg::VAL_W-1])) begin
      coord = vsc_pkg::S32_MIN;
    end else begin
      coord = sum[vsc_pkg::VAL_W-1:0];
    end
  end

endmodule

### sv/vsc_merge.sv
// merge stage: class flags, keep decision and per-cell min/max tree
module vsc_merge (
  input  vsc_pkg::lane_flags_t             flags [vsc_pkg::NUM_CORNERS],
  input  logic signed [vsc_pkg::VAL_W-1:0] corners [vsc_pkg::NUM_CORNERS],
  input  logic [vsc_pkg::MASK_W-1:0]       keep_mask,
  input  logic                             in_grid,
  output vsc_pkg::cls_t                    cls,
  output logic signed [vsc_pkg::VAL_W-1:0] cell_min,
  output logic signed [vsc_pkg::VAL_W-1:0] cell_max
);

  logic any_pos;
  logic any_neg;
  logic signed [vsc_pkg::VAL_W-1:0] lo4 [4];
  logic signed [vsc_pkg::VAL_W-1:0] hi4 [4];
  logic signed [vsc_pkg::VAL_W-1:0] lo2 [2];
  logic signed [vsc_pkg::VAL_W-1:0] hi2 [2];

  always_comb begin
    any_pos = 1'b0;
    any_neg = 1'b0;
    for (int n = 0; n < vsc_pkg::NUM_CORNERS; n++) begin
      any_pos = any_pos | flags[n].pos;
      any_neg = any_neg | flags[n].neg;
    end
    cls.interior = !any_pos;
    cls.outside  = !any_neg;
    cls.crossing = any_pos && any_neg;
    cls.kept     = in_grid &&
                   ((cls.crossing && keep_mask[vsc_pkg::KEEP_CROSSING]) ||
                    (cls.interior && keep_mask[vsc_pkg::KEEP_INSIDE])   ||
                    (cls.outside  && keep_mask[vsc_pkg::KEEP_OUTSIDE]));
  end

  // three-level compare tree
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      lo4[n] = (corners[2*n] < corners[2*n+1]) ? corners[2*n] : corners[2*n+1];
      hi4[n] = (corners[2*n] > corners[2*n+1]) ? corners[2*n] : corners[2*n+1];
    end
    for (int n = 0; n < 2; n++) begin
      lo2[n] = (lo4[2*n] < lo4[2*n+1]) ? lo4[2*n] : lo4[2*n+1];
      hi2[n] = (hi4[2*n] > hi4[2*n+1]) ? hi4[2*n] : hi4[2*n+1];
    end
    cell_min = (lo2[0] < lo2[1]) ? lo2[0] : lo2[1];
    cell_max = (hi2[0] > hi2[1]) ? hi2[0] : hi2[1];
  end

endmodule

### sv/voxel_sign_classifier.sv
// voxel sign classifier top level: lanes, merge, running extremes, output register
//
//   channel   signals                                 direction
//   -------   -------------------------------------   ---------
//   input     in_valid / in_ready, corners, indices   into block
//   output    out_valid / out_ready, flags, extremes  out of block
//   config    cfg_we, cfg_index, cfg_data             into block
//
// one cell per cycle sustained while the output is taken; an input beat passes the
// lane/merge register, then fold and output register, on its way to the result beat
// the 31x10 index multiply in each axis lane is registered before the origin add
// the running min/max fold is a single compare per extreme in the second stage
// rst clears control state, configuration and the running extremes
// a stalled output holds its beat while the first stage may still fill
module voxel_sign_classifier #(
  parameter int CELLS_PER_AXIS = vsc_pkg::CELLS_PER_AXIS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_we,
  input  logic [vsc_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [vsc_pkg::VAL_W-1:0]              cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_000,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_100,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_010,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_110,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_001,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_101,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_011,
  input  logic signed [vsc_pkg::VAL_W-1:0]       corner_111,
  input  logic [vsc_pkg::IDX_W-1:0]              cell_i,
  input  logic [vsc_pkg::IDX_W-1:0]              cell_j,
  input  logic [vsc_pkg::IDX_W-1:0]              cell_k,
  input  logic                                   frame_start,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   cell_kept,
  output logic                                   is_inside,
  output logic                                   is_outside,
  output logic                                   is_crossing,
  output logic signed [vsc_pkg::VAL_W-1:0]       cell_origin_x,
  output logic signed [vsc_pkg::VAL_W-1:0]       cell_origin_y,
  output logic signed [vsc_pkg::VAL_W-1:0]       cell_origin_z,
  output logic signed [vsc_pkg::VAL_W-1:0]       lowest_seen,
  output logic signed [vsc_pkg::VAL_W-1:0]       highest_seen
);

  // configuration registers
  logic [vsc_pkg::MASK_W-1:0]        keep_mask;
  logic signed [vsc_pkg::VAL_W-1:0]  origin_x;
  logic signed [vsc_pkg::VAL_W-1:0]  origin_y;
  logic signed [vsc_pkg::VAL_W-1:0]  origin_z;
  logic [vsc_pkg::SIZE_W-1:0]        cell_size;

  // running extremes since the last frame start
  logic signed [vsc_pkg::VAL_W-1:0]  running_low;
  logic signed [vsc_pkg::VAL_W-1:0]  running_high;
  logic signed [vsc_pkg::VAL_W-1:0]  running_low_next;
  logic signed [vsc_pkg::VAL_W-1:0]  running_high_next;
  logic signed [vsc_pkg::VAL_W-1:0]  base_low;
  logic signed [vsc_pkg::VAL_W-1:0]  base_high;

  // lanes and merge
  logic signed [vsc_pkg::VAL_W-1:0]  corners [vsc_pkg::NUM_CORNERS];
  vsc_pkg::lane_flags_t              flags   [vsc_pkg::NUM_CORNERS];
  vsc_pkg::cls_t                     cls;
  logic signed [vsc_pkg::VAL_W-1:0]  cell_min;
  logic signed [vsc_pkg::VAL_W-1:0]  cell_max;
  logic                              in_grid;

  // first stage registers
  logic                              s1_valid;
  logic                              s1_valid_next;
  vsc_pkg::cls_t                     s1_cls;
  logic signed [vsc_pkg::VAL_W-1:0]  s1_min;
  logic signed [vsc_pkg::VAL_W-1:0]  s1_max;
  logic                              s1_frame;

  // coordinates out of the axis lanes
  logic signed [vsc_pkg::VAL_W-1:0]  coord_x;
  logic signed [vsc_pkg::VAL_W-1:0]  coord_y;
  logic signed [vsc_pkg::VAL_W-1:0]  coord_z;

  logic                              s1_load;
  logic                              out_load;
  logic                              out_valid_next;

  // handshake: output register frees when empty or taken this cycle
  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign s1_load  = in_valid && in_ready;

  always_comb begin
    s1_valid_next = s1_valid;
    if (s1_load) begin
      s1_valid_next = 1'b1;
    end else if (out_load) begin
      s1_valid_next = 1'b0;
    end
    out_valid_next = out_valid;
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid  <= s1_valid_next;
      out_valid <= out_valid_next;
    end
  end

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_mask <= vsc_pkg::KEEP_MASK_RESET;
      origin_x  <= '0;
      origin_y  <= '0;
      origin_z  <= '0;
      cell_size <= vsc_pkg::CELL_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vsc_pkg::REG_KEEP_MASK: keep_mask <= cfg_data[vsc_pkg::MASK_W-1:0];
        vsc_pkg::REG_ORIGIN_X:  origin_x  <= cfg_data;
        vsc_pkg::REG_ORIGIN_Y:  origin_y  <= cfg_data;
        vsc_pkg::REG_ORIGIN_Z:  origin_z  <= cfg_data;
        vsc_pkg::REG_CELL_SIZE: cell_size <= cfg_data[vsc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // corner lanes, one per cube corner
  always_comb begin
    corners[0] = corner_000;
    corners[1] = corner_100;
    corners[2] = corner_010;
    corners[3] = corner_110;
    corners[4] = corner_001;
    corners[5] = corner_101;
    corners[6] = corner_011;
    corners[7] = corner_111;
  end

  for (genvar g = 0; g < vsc_pkg::NUM_CORNERS; g++) begin : g_lane
    vsc_corner_lane u_lane (
      .corner (corners[g]),
      .flags  (flags[g])
    );
  end

  // grid bound check on all three indexes
  localparam logic [vsc_pkg::GRID_CMP_W-1:0] GRID_LIMIT =
    vsc_pkg::GRID_CMP_W'(CELLS_PER_AXIS);

  assign in_grid = (vsc_pkg::GRID_CMP_W'(cell_i) < GRID_LIMIT) &&
                   (vsc_pkg::GRID_CMP_W'(cell_j) < GRID_LIMIT) &&
                   (vsc_pkg::GRID_CMP_W'(cell_k) < GRID_LIMIT);

  vsc_merge u_merge (
    .flags     (flags),
    .corners   (corners),
    .keep_mask (keep_mask),
    .in_grid   (in_grid),
    .cls       (cls),
    .cell_min  (cell_min),
    .cell_max  (cell_max)
  );

  // first stage: classification and per-cell extremes
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_cls   <= cls;
      s1_min   <= cell_min;
      s1_max   <= cell_max;
      s1_frame <= frame_start;
    end
  end

  // axis lanes: multiply in stage one, saturating add in stage two
  vsc_axis_lane u_axis_x (
    .clk       (clk),
    .load      (s1_load),
    .cell_idx  (cell_i),
    .cell_size (cell_size),
    .origin    (origin_x),
    .coord     (coord_x)
  );

  vsc_axis_lane u_axis_y (
    .clk       (clk),
    .load      (s1_load),
    .cell_idx  (cell_j),
    .cell_size (cell_size),
    .origin    (origin_y),
    .coord     (coord_y)
  );

  vsc_axis_lane u_axis_z (
    .clk       (clk),
    .load      (s1_load),
    .cell_idx  (cell_k),
    .cell_size (cell_size),
    .origin    (origin_z),
    .coord     (coord_z)
  );

  // fold the cell extremes into the running pair; frame start restarts it
  always_comb begin
    base_low  = s1_frame ? vsc_pkg::S32_MAX : running_low;
    base_high = s1_frame ? vsc_pkg::S32_MIN : running_high;
    running_low_next  = base_low;
    running_high_next = base_high;
    if (s1_cls.kept) begin
      if (s1_min < base_low) begin
        running_low_next = s1_min;
      end
      if (s1_max > base_high) begin
        running_high_next = s1_max;
      end
    end
  end

  // running state advances in beat order as items leave stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      running_low  <= vsc_pkg::S32_MAX;
      running_high <= vsc_pkg::S32_MIN;
    end else if (out_load) begin
      running_low  <= running_low_next;
      running_high <= running_high_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      cell_kept     <= s1_cls.kept;
      is_inside     <= s1_cls.interior;
      is_outside    <= s1_cls.outside;
      is_crossing   <= s1_cls.crossing;
      cell_origin_x <= coord_x;
      cell_origin_y <= coord_y;
      cell_origin_z <= coord_z;
      lowest_seen   <= running_low_next;
      highest_seen  <= running_high_next;
    end
  end

endmodule

### tb/sv/tb_top.sv
// self-checking testbench for the voxel sign classifier
`timescale 1ns / 100ps

module tb_top;
  import vsc_pkg::*;

  localparam int RAND_PHASES     = 8;
  localparam int CELLS_PER_PHASE = 205;
  localparam int SETTLE_CYCLES   = 8;
  localparam int SQUEEZE_CYCLES  = 120;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(CELLS_PER_AXIS - 1);

  // one cell as offered on the input channel
  typedef struct packed {
    logic [NUM_CORNERS-1:0][VAL_W-1:0] corner;
    logic [IDX_W-1:0]                  i;
    logic [IDX_W-1:0]                  j;
    logic [IDX_W-1:0]                  k;
    logic                              frame_start;
  } cell_t;

  // one result beat, flags plus coordinates and extremes
  typedef struct packed {
    logic             kept;
    logic             interior;
    logic             outside;
    logic             crossing;
    logic [VAL_W-1:0] org_x;
    logic [VAL_W-1:0] org_y;
    logic [VAL_W-1:0] org_z;
    logic [VAL_W-1:0] low;
    logic [VAL_W-1:0] high;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // every block input starts at a known value
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_KEEP_MASK;
  logic [VAL_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 out_ready = 1'b0;
  cell_t                cell_drv  = '0;

  logic         in_ready;
  logic         out_valid;
  cell_result_t got;

  // register mirror and running extremes, tracked in step with accepted beats
  logic [MASK_W-1:0]       keep_sel;
  logic signed [VAL_W-1:0] grid_org_x;
  logic signed [VAL_W-1:0] grid_org_y;
  logic signed [VAL_W-1:0] grid_org_z;
  logic [SIZE_W-1:0]       cell_step;
  logic signed [VAL_W-1:0] run_lo;
  logic signed [VAL_W-1:0] run_hi;

  cell_t        cells_pending[$];
  cell_result_t results_due[$];
  int           cells_sent   = 0;
  int           results_seen = 0;
  int           mismatches   = 0;

  // traffic shaping, changed by the sequencer between phases
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic squeeze_go = 1'b0;
  logic hold_off = 1'b0;

  always #10 clk = ~clk;

  voxel_sign_classifier u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .corner_000    (cell_drv.corner[0]),
    .corner_100    (cell_drv.corner[1]),
    .corner_010    (cell_drv.corner[2]),
    .corner_110    (cell_drv.corner[3]),
    .corner_001    (cell_drv.corner[4]),
    .corner_101    (cell_drv.corner[5]),
    .corner_011    (cell_drv.corner[6]),
    .corner_111    (cell_drv.corner[7]),
    .cell_i        (cell_drv.i),
    .cell_j        (cell_drv.j),
    .cell_k        (cell_drv.k),
    .frame_start   (cell_drv.frame_start),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_kept     (got.kept),
    .is_inside     (got.interior),
    .is_outside    (got.outside),
    .is_crossing   (got.crossing),
    .cell_origin_x (got.org_x),
    .cell_origin_y (got.org_y),
    .cell_origin_z (got.org_z),
    .lowest_seen   (got.low),
    .highest_seen  (got.high)
  );

  // origin plus step times index, computed wide and clamped to 32 bits
  function automatic logic [VAL_W-1:0] place_coord(logic signed [VAL_W-1:0] org,
                                                   logic [IDX_W-1:0] idx);
    longint sum;
    sum = longint'(org) + longint'(cell_step) * longint'(idx);
    if (sum > longint'(S32_MAX)) return S32_MAX;
    if (sum < longint'(S32_MIN)) return S32_MIN;
    return sum[VAL_W-1:0];
  endfunction

  // classify one accepted cell and fold it into the running extremes
  function automatic cell_result_t classify_cell(cell_t c);
    cell_result_t            r;
    logic                    any_pos;
    logic                    any_neg;
    logic                    in_grid;
    logic signed [VAL_W-1:0] v;
    any_pos = 1'b0;
    any_neg = 1'b0;
    for (int n = 0; n < NUM_CORNERS; n++) begin
      v = $signed(c.corner[n]);
      if (v > 0) any_pos = 1'b1;
      if (v < 0) any_neg = 1'b1;
    end
    r.interior = !any_pos;
    r.outside  = !any_neg;
    r.crossing = any_pos && any_neg;

    // frame start wipes the extremes before this cell counts
    if (c.frame_start) begin
      run_lo = S32_MAX;
      run_hi = S32_MIN;
    end

    // cells past the grid edge are reported but never kept
    in_grid = (int'(c.i) < CELLS_PER_AXIS) && (int'(c.j) < CELLS_PER_AXIS) &&
              (int'(c.k) < CELLS_PER_AXIS);
    r.kept = in_grid &&
             ((r.crossing && keep_sel[KEEP_CROSSING]) ||
              (r.interior && keep_sel[KEEP_INSIDE]) ||
              (r.outside && keep_sel[KEEP_OUTSIDE]));
    if (r.kept) begin
      for (int n = 0; n < NUM_CORNERS; n++) begin
        v = $signed(c.corner[n]);
        if (v < run_lo) run_lo = v;
        if (v > run_hi) run_hi = v;
      end
    end

    r.org_x = place_coord(grid_org_x, c.i);
    r.org_y = place_coord(grid_org_y, c.j);
    r.org_z = place_coord(grid_org_z, c.k);
    r.low   = run_lo;
    r.high  = run_hi;
    return r;
  endfunction

  // input side: offer pending cells, predict on every accepted beat
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) results_due = {results_due, classify_cell(cell_drv)};
      if (cells_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cell_drv <= cells_pending.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %h, got %h", name, want, seen);
      mismatches++;
    end
  endfunction

  // output side: random back-pressure, compare each result beat in order
  always @(posedge clk) begin
    cell_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result beat with nothing outstanding");
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("cell_kept", want.kept, got.kept);
          check_field("is_inside", want.interior, got.interior);
          check_field("is_outside", want.outside, got.outside);
          check_field("is_crossing", want.crossing, got.crossing);
          check_field("cell_origin_x", want.org_x, got.org_x);
          check_field("cell_origin_y", want.org_y, got.org_y);
          check_field("cell_origin_z", want.org_z, got.org_z);
          check_field("lowest_seen", want.low, got.low);
          check_field("highest_seen", want.high, got.high);
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off, counted here while the sender keeps offering
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (SQUEEZE_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // one register write per edge; the mirror follows the written value
  task automatic reg_write(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_KEEP_MASK: keep_sel   = data[MASK_W-1:0];
      REG_ORIGIN_X:  grid_org_x = data;
      REG_ORIGIN_Y:  grid_org_y = data;
      REG_ORIGIN_Z:  grid_org_z = data;
      REG_CELL_SIZE: cell_step  = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // raw mask and size may carry bits above the register width on purpose
  task automatic set_config(logic [VAL_W-1:0] mask_raw, logic [VAL_W-1:0] ox,
                            logic [VAL_W-1:0] oy, logic [VAL_W-1:0] oz,
                            logic [VAL_W-1:0] size_raw);
    reg_write(REG_KEEP_MASK, mask_raw);
    reg_write(REG_ORIGIN_X, ox);
    reg_write(REG_ORIGIN_Y, oy);
    reg_write(REG_ORIGIN_Z, oz);
    reg_write(REG_CELL_SIZE, size_raw);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_cell(cell_t c);
    cells_pending = {cells_pending, c};
    cells_sent++;
  endtask

  // block until every queued cell has come back as a result
  task automatic drain();
    while (results_seen != cells_sent) @(posedge clk);
  endtask

  function automatic cell_t flat_cell(logic [VAL_W-1:0] v, logic [IDX_W-1:0] i,
                                      logic [IDX_W-1:0] j, logic [IDX_W-1:0] k,
                                      logic fs);
    cell_t c;
    for (int n = 0; n < NUM_CORNERS; n++) c.corner[n] = v;
    c.i = i;
    c.j = j;
    c.k = k;
    c.frame_start = fs;
    return c;
  endfunction

  // corner values lean toward zero, the extremes and small magnitudes
  function automatic logic signed [VAL_W-1:0] rand_corner();
    case ($urandom_range(9))
      0:       return '0;
      1:       return S32_MAX;
      2:       return S32_MIN;
      3, 4:    return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_index();
    case ($urandom_range(9))
      0:       return '0;
      1:       return IDX_MAX;
      default: return IDX_W'($urandom_range(CELLS_PER_AXIS - 1));
    endcase
  endfunction

  // pick a target class, then bend the corners toward it
  function automatic cell_t rand_cell();
    cell_t                   c;
    logic signed [VAL_W-1:0] v;
    int                      shape;
    shape = $urandom_range(9);
    for (int n = 0; n < NUM_CORNERS; n++) begin
      v = rand_corner();
      case (shape)
        4, 5: if (v > 0) v = -v;
        6, 7: if (v < 0) v = ~v;
        8:    v = '0;
        9:    v = ($urandom_range(3) == 0) ? v : '0;
        default: ;
      endcase
      c.corner[n] = v;
    end
    c.i = rand_index();
    c.j = rand_index();
    c.k = rand_index();
    c.frame_start = ($urandom_range(19) == 0);
    return c;
  endfunction

  function automatic logic [VAL_W-1:0] rand_origin();
    case ($urandom_range(5))
      0:       return S32_MAX;
      1:       return S32_MIN;
      2:       return '0;
      3, 4:    return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VAL_W-1:0] rand_size();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  initial begin
    cell_t c;

    // mirror starts at the block's reset values
    keep_sel   = KEEP_MASK_RESET;
    grid_org_x = '0;
    grid_org_y = '0;
    grid_org_z = '0;
    cell_step  = CELL_SIZE_RESET;
    run_lo     = S32_MAX;
    run_hi     = S32_MIN;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration: class corners and value extremes
    queue_cell(flat_cell('0, '0, '0, '0, 1'b1));          // all zero: inside and outside
    queue_cell(flat_cell(S32_MAX, IDX_MAX, IDX_MAX, IDX_MAX, 1'b0));
    queue_cell(flat_cell(S32_MIN, '0, IDX_MAX, 10'd512, 1'b0));
    c = flat_cell(S32_MAX, 10'd1, 10'd2, 10'd3, 1'b0);
    c.corner[0] = S32_MIN;                                 // crossing at the extremes
    queue_cell(c);
    queue_cell(flat_cell('1, 10'd5, 10'd6, 10'd7, 1'b1));  // -1 everywhere, fresh frame
    queue_cell(flat_cell(32'd1, 10'd8, 10'd9, 10'd10, 1'b0));
    c = flat_cell('0, 10'd11, '0, '0, 1'b0);
    c.corner[7] = 32'd1;                                   // zeros plus one positive
    queue_cell(c);
    c = flat_cell('0, '0, 10'd11, '0, 1'b0);
    c.corner[3] = '1;                                      // zeros plus one negative
    queue_cell(c);
    c = flat_cell('0, '0, '0, 10'd11, 1'b0);
    c.corner[2] = '1;
    c.corner[5] = 32'd1;
    queue_cell(c);
    queue_cell(flat_cell(32'h0001_0000, IDX_MAX, '0, 10'd341, 1'b1));
    for (int n = 0; n < 2; n++) queue_cell(rand_cell());
    drain();

    // mask written with only unused bits set keeps nothing; origins overflow
    set_config(32'hFFFF_FFF8, S32_MAX, S32_MIN, 32'hFFFF_0000, 32'hFFFF_FFFF);
    queue_cell(flat_cell('0, IDX_MAX, IDX_MAX, IDX_MAX, 1'b1));
    queue_cell(flat_cell(32'd7, '0, '0, '0, 1'b0));
    queue_cell(flat_cell('1, 10'd1, 10'd1, 10'd1, 1'b0));
    drain();

    // crossing only, zero step
    set_config(32'h0000_0009, S32_MIN, S32_MAX, '0, '0);
    c = flat_cell(32'd3, 10'd100, 10'd200, 10'd300, 1'b1);
    c.corner[6] = 32'hFFFF_FFFD;
    queue_cell(c);
    queue_cell(flat_cell(32'hFFFF_0000, IDX_MAX, IDX_MAX, IDX_MAX, 1'b0));
    queue_cell(flat_cell(32'h0002_0000, '0, '0, '0, 1'b0));
    drain();

    // inside only, then outside only
    set_config(32'h0000_0002, 32'hFFFD_0000, 32'h0001_0000, 32'h7FFF_0000, 32'h0000_8000);
    queue_cell(flat_cell(32'hFFFF_8000, IDX_MAX, 10'd3, 10'd4, 1'b1));
    queue_cell(flat_cell(32'h0000_8000, 10'd2, 10'd3, 10'd4, 1'b0));
    drain();
    set_config(32'h0000_0004, '0, '0, '0, 32'h0001_0000);
    queue_cell(flat_cell(32'h0000_8000, 10'd2, 10'd3, 10'd4, 1'b1));
    queue_cell(flat_cell(32'hFFFF_8000, 10'd2, 10'd3, 10'd4, 1'b0));
    drain();

    // random phases, each with its own register setting and traffic shape
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_config($urandom, rand_origin(), rand_origin(), rand_origin(), rand_size());
      @(posedge clk);
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_stall_pct <= 0;  end
        1: begin send_idle_pct <= 88; recv_stall_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_stall_pct <= 88; end
        default: begin send_idle_pct <= 35; recv_stall_pct <= 35; end
      endcase
      for (int n = 0; n < CELLS_PER_PHASE; n++) queue_cell(rand_cell());
      // once, starve the output long enough to back the block up to its input
      if (p == 4) squeeze_go <= 1'b1;
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
